// ----- sv/spdr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SDRAM presence-detect responder package
// Table contents, module shapes and the geometry record that the stages share.
// ----------------------------------------------------------------------------
package spdr_pkg;

    localparam int ROM_BYTES   = 64;
    localparam int IDX_W       = $clog2(ROM_BYTES);
    localparam int BASE_BYTES  = 64;
    localparam int BASE_IDX_W  = 6;
    localparam int SHAPE_COUNT = 4;
    localparam int MAX_MODULES = 3;
    localparam int SIZE_W      = 12;

    localparam int ROW_IDX  = 3;
    localparam int COL_IDX  = 4;
    localparam int RANK_IDX = 5;
    localparam int DENS_IDX = 31;
    localparam logic [IDX_W-1:0] CHK_IDX = IDX_W'(ROM_BYTES - 1);

    localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd1536;

    localparam logic [7:0] BASE_TABLE [BASE_BYTES] = '{
        8'h80, 8'h08, 8'h04, 8'h0C, 8'h09, 8'h01, 8'h40, 8'h00,
        8'h01, 8'h0A, 8'h07, 8'h00, 8'h80, 8'h08, 8'h00, 8'h01,
        8'h0F, 8'h04, 8'h0C, 8'h01, 8'h01, 8'h00, 8'h0E, 8'h0A,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h12, 8'h00
    };

    typedef struct packed {
        logic [9:0] mb;
        logic [7:0] rows;
        logic [7:0] cols;
        logic [7:0] ranks;
        logic [7:0] dens;
    } spdr_shape_t;

    typedef struct packed {
        spdr_shape_t shape;
        logic [1:0]  count;
        logic [7:0]  checksum;
    } spdr_geom_t;

    localparam spdr_shape_t SHAPES [SHAPE_COUNT] = '{
        '{mb: 10'd64,  rows: 8'd12, cols: 8'd9,  ranks: 8'd1, dens: 8'h10},
        '{mb: 10'd128, rows: 8'd12, cols: 8'd10, ranks: 8'd1, dens: 8'h20},
        '{mb: 10'd256, rows: 8'd13, cols: 8'd10, ranks: 8'd1, dens: 8'h40},
        '{mb: 10'd512, rows: 8'd13, cols: 8'd10, ranks: 8'd2, dens: 8'h40}
    };

    // Sum of the fixed bytes that no shape overrides, checksum byte excluded.
    function automatic logic [7:0] base_rest_sum();
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < BASE_BYTES; k++) begin
            if (k != ROW_IDX && k != COL_IDX && k != RANK_IDX && k != DENS_IDX
                && k != ROM_BYTES - 1) begin
                acc = acc + BASE_TABLE[k];
            end
        end
        return acc;
    endfunction

    localparam logic [7:0] BASE_REST = base_rest_sum();

endpackage : spdr_pkg
`default_nettype wire

// ----- sv/sdram_spd_responder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A request passes through the input register and then the result register to the output.
// Throughput: one request per cycle while out_stall is low, held by the input and result registers.
// A size write takes effect for requests that reach the result register after it.
// Reset empties both registers and sets the size to 1536 MB (three 512 MB modules).
// ----------------------------------------------------------------------------
// SDRAM presence-detect responder
// Answers reads of a presence-detect ROM shaped by the configured memory size.
// ----------------------------------------------------------------------------
module sdram_spd_responder
    import spdr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] ram_size_mb,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  register_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       spd_byte,
    output logic [1:0]       module_count,
    output logic [9:0]       module_size_mb
);

    spdr_geom_t       geom;
    logic [7:0]       lookup_byte;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [1:0]       out_count_reg;
    logic [9:0]       out_mb_reg;
    logic             s2_ready;
    logic             s1_load;

    assign cfg_ready = 1'b1;

    spdr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_data (ram_size_mb),
        .geom    (geom)
    );

    spdr_lookup u_lookup (
        .idx  (s1_idx_reg),
        .geom (geom),
        .data (lookup_byte)
    );

    assign s2_ready = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s2_ready;
    assign s1_load  = in_valid && !in_stall;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s2_ready) begin
            s1_valid_next = 1'b0;
        end
        if (s1_load) begin
            s1_valid_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (s2_ready) begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_load) begin
            s1_idx_reg <= register_index[IDX_W-1:0];
        end
        if (s2_ready && s1_valid_reg) begin
            out_byte_reg  <= lookup_byte;
            out_count_reg <= geom.count;
            out_mb_reg    <= geom.shape.mb;
        end
    end

    assign out_valid      = out_valid_reg;
    assign spd_byte       = out_byte_reg;
    assign module_count   = out_count_reg;
    assign module_size_mb = out_mb_reg;

    a_load_fills_stage : assert property (@(posedge clk) disable iff (!rst_n)
        s1_load |=> s1_valid_reg)
        else $error("Accepted request did not reach the input register.");

    a_held_stage_stable : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_idx_reg)))
        else $error("Held request changed while the result register was full.");

    a_result_shape : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (module_count != 2'd0 && $onehot(module_size_mb)
                       && module_size_mb >= 10'd64))
        else $error("Result carries an impossible module count or size.");

    a_result_moves_up : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> out_valid_reg)
        else $error("Request in the input register was lost.");

endmodule : sdram_spd_responder
`default_nettype wire

// ----- sv/spdr_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Size register and geometry decode
// Holds the configured memory size and derives module count, shape and checksum.
// ----------------------------------------------------------------------------
module spdr_cfg
    import spdr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [SIZE_W-1:0] wr_data,
    output spdr_geom_t             geom
);

    logic [SIZE_W-1:0] size_reg;
    logic              found;
    spdr_shape_t       shape_sel;
    logic [1:0]        count_sel;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            size_reg <= SIZE_RESET;
        end
        else if (wr_en) begin
            size_reg <= wr_data;
        end
    end

    // Fewest modules first, and smaller shapes first within one count.
    always_comb begin
        found     = 1'b0;
        shape_sel = SHAPES[0];
        count_sel = 2'd1;
        for (int n = 1; n <= MAX_MODULES; n++) begin
            for (int s = 0; s < SHAPE_COUNT; s++) begin
                if (!found && size_reg == SIZE_W'(int'(SHAPES[s].mb) * n)) begin
                    found     = 1'b1;
                    shape_sel = SHAPES[s];
                    count_sel = 2'(n);
                end
            end
        end
    end

    always_comb begin
        geom.shape    = shape_sel;
        geom.count    = count_sel;
        geom.checksum = BASE_REST + shape_sel.rows + shape_sel.cols
                        + shape_sel.ranks + shape_sel.dens;
    end

endmodule : spdr_cfg
`default_nettype wire

// ----- sv/spdr_lookup.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Presence-detect byte lookup
// Selects the table byte, a shape override or the checksum for one index.
// ----------------------------------------------------------------------------
module spdr_lookup
    import spdr_pkg::*;
(
    input  wire logic [IDX_W-1:0] idx,
    input  wire spdr_geom_t       geom,
    output logic [7:0]            data
);

    always_comb begin
        if (idx == CHK_IDX) begin
            data = geom.checksum;
        end
        else if (idx == IDX_W'(ROW_IDX)) begin
            data = geom.shape.rows;
        end
        else if (idx == IDX_W'(COL_IDX)) begin
            data = geom.shape.cols;
        end
        else if (idx == IDX_W'(RANK_IDX)) begin
            data = geom.shape.ranks;
        end
        else if (idx == IDX_W'(DENS_IDX)) begin
            data = geom.shape.dens;
        end
        else if (32'(idx) < BASE_BYTES) begin
            data = BASE_TABLE[idx[BASE_IDX_W-1:0]];
        end
        else begin
            data = 8'h00;
        end
    end

endmodule : spdr_lookup
`default_nettype wire
